// ----- rtl/core/prq_pkg.sv -----
package prq_pkg;

    // Default build widths.
    localparam int PRQ_POS_BITS  = 12;
    localparam int PRQ_TIME_BITS = 32;

    // Depth of the queue between the front and the back.
    localparam int PRQ_QDEPTH = 2;

    // Register values after reset.
    localparam logic [1:0]  RST_MODE    = 2'd0;
    localparam logic [12:0] RST_WIDTH   = 13'd480;
    localparam logic [12:0] RST_HEIGHT  = 13'd272;
    localparam logic [15:0] RST_CONFIRM = 16'd25;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_WIDTH   = 2'd1;
    localparam logic [1:0] REG_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_CONFIRM = 2'd3;

    // Sensitivity modes; the unused code behaves as normal.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_LOW    = 2'd1;
    localparam logic [1:0] MODE_HIGH   = 2'd2;

    // Input commands.
    localparam logic [2:0] CMD_REPORT     = 3'd0;
    localparam logic [2:0] CMD_TICK       = 3'd1;
    localparam logic [2:0] CMD_FLUSH      = 3'd2;
    localparam logic [2:0] CMD_REBASELINE = 3'd3;
    localparam logic [2:0] CMD_DISCONNECT = 3'd4;
    localparam logic [2:0] CMD_SET_POS    = 3'd5;

    // Event kinds.
    localparam logic [2:0] EV_MOVE   = 3'd0;
    localparam logic [2:0] EV_DOWN   = 3'd1;
    localparam logic [2:0] EV_UP     = 3'd2;
    localparam logic [2:0] EV_BACK   = 3'd3;
    localparam logic [2:0] EV_SCROLL = 3'd4;

    // Bit positions of the buttons.
    localparam int BIT_LEFT  = 0;
    localparam int BIT_RIGHT = 1;

    // Scaled motion and the carry left for the next report.
    typedef struct packed {
        logic signed [9:0] delta;
        logic signed [1:0] carry;
    } t_scaled;

    // All events caused by one input item; they share cursor and time.
    typedef struct packed {
        logic [2:0]        count;
        logic [3:0][2:0]   kind;
        logic [3:0][1:0]   btn;
        logic signed [7:0] scroll;
        logic [11:0]       pointer_x;
        logic [11:0]       pointer_y;
        logic [31:0]       time_stamp;
    } t_bundle;

    // Scale a delta: high doubles, low halves toward zero and keeps the remainder.
    function automatic t_scaled scale_delta(input logic signed [7:0] d,
                                            input logic signed [1:0] carry,
                                            input logic [1:0] mode);
        t_scaled           res;
        logic signed [9:0] acc;
        acc = $signed({{2{d[7]}}, d}) + $signed({{8{carry[1]}}, carry});
        res.carry = 2'sb00;
        case (mode)
            MODE_HIGH: begin
                res.delta = $signed({d[7], d, 1'b0});
            end
            MODE_LOW: begin
                if (acc[9]) begin
                    res.delta = (acc + 10'sd1) >>> 1;
                end else begin
                    res.delta = acc >>> 1;
                end
                if (acc[0]) begin
                    res.carry = acc[9] ? 2'sb11 : 2'sb01;
                end
            end
            default: begin
                res.delta = $signed({{2{d[7]}}, d});
            end
        endcase
        return res;
    endfunction

    // Append one event to a bundle.
    function automatic t_bundle push_event(input t_bundle b, input logic [2:0] kind,
                                           input logic [1:0] btn);
        t_bundle res;
        res = b;
        if (b.count < 3'd4) begin
            res.kind[b.count[1:0]] = kind;
            res.btn[b.count[1:0]]  = btn;
            res.count              = b.count + 3'd1;
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/prq_if.sv -----
// Input item channel.
interface prq_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic [7:0]        button_byte;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
    logic signed [7:0] wheel_step;
    logic [11:0]       new_x;
    logic [11:0]       new_y;

    modport source(output valid, command, button_byte, move_x, move_y, wheel_step,
                   new_x, new_y, input ready);
    modport sink(input valid, command, button_byte, move_x, move_y, wheel_step,
                 new_x, new_y, output ready);
endinterface

// Event channel.
interface prq_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        event_kind;
    logic [11:0]       pointer_x;
    logic [11:0]       pointer_y;
    logic signed [7:0] scroll;
    logic [1:0]        button_bits;
    logic [31:0]       time_stamp;
    logic              last_of_run;

    modport source(output valid, event_kind, pointer_x, pointer_y, scroll, button_bits,
                   time_stamp, last_of_run, input ready);
    modport sink(input valid, event_kind, pointer_x, pointer_y, scroll, button_bits,
                 time_stamp, last_of_run, output ready);
endinterface

// Configuration write channel.
interface prq_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/pointer_report_qualifier.sv -----
// Channel   Direction  Payload
// i_in      in         command, button_byte, move_x, move_y, wheel_step, new_x, new_y
// o_out     out        event_kind, pointer_x, pointer_y, scroll, button_bits,
//                      time_stamp, last_of_run
// i_cfg     in         index, data (always ready)
//
// The front takes one transaction per cycle while the bundle queue has room and
// settles all state for it in that cycle. The back sends one event per cycle while
// the output is ready, so an item that causes N events holds the back until all N
// are sent; the first event goes through the bundle queue and the output register.
// A stalled output backs up the queue; once it holds two bundles the input is held off.
// Reset is synchronous, active low, and spares only queue storage and event payload.
module pointer_report_qualifier
    import prq_pkg::*;
#(
    parameter int POS_BITS  = PRQ_POS_BITS,
    parameter int TIME_BITS = PRQ_TIME_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prq_in_if.sink    i_in,
    prq_out_if.source o_out,
    prq_cfg_if.sink   i_cfg
);

    logic    q_push, q_ready, q_pop, q_valid;
    t_bundle q_wdata, q_rdata;

    // Front: decode commands and update the qualifier state.
    prq_front #(
        .POS_BITS (POS_BITS),
        .TIME_BITS(TIME_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_ready(q_ready),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    // Queue of event bundles.
    prq_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .o_ready(q_ready),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_rdata)
    );

    // Back: send events one at a time.
    prq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (q_rdata),
        .o_q_pop  (q_pop),
        .o_out    (o_out)
    );

endmodule

// ----- rtl/core/prq_front.sv -----
module prq_front
    import prq_pkg::*;
#(
    parameter int POS_BITS  = PRQ_POS_BITS,
    parameter int TIME_BITS = PRQ_TIME_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    prq_in_if.sink  i_in,
    prq_cfg_if.sink i_cfg,
    input  logic    i_q_ready,
    output logic    o_q_push,
    output t_bundle o_q_data
);

    // Signed width for cursor arithmetic, wide enough for the size registers too.
    localparam int CW = (POS_BITS + 3 > 14) ? POS_BITS + 3 : 14;
    localparam logic signed [CW-1:0] LIM = CW'(2 ** POS_BITS);
    localparam logic [POS_BITS-1:0] RST_X = POS_BITS'(RST_WIDTH / 2);
    localparam logic [POS_BITS-1:0] RST_Y = POS_BITS'(RST_HEIGHT / 2);

    // Clamp a coordinate into 0 .. size-1, with the size limited to 1 .. 2^POS_BITS.
    function automatic logic [POS_BITS-1:0] clamp_axis(input logic signed [CW-1:0] v,
                                                       input logic [12:0] size);
        logic signed [CW-1:0] sz;
        logic signed [CW-1:0] sz_m1;
        sz = (size == 13'd0) ? CW'(1) : $signed(CW'(size));
        if (sz > LIM) begin
            sz = LIM;
        end
        sz_m1 = sz - CW'(1);
        if (v < 0) begin
            return '0;
        end else if (v >= sz) begin
            return sz_m1[POS_BITS-1:0];
        end
        return v[POS_BITS-1:0];
    endfunction

    // Configuration registers.
    logic [1:0]  r_mode;
    logic [12:0] r_width;
    logic [12:0] r_height;
    logic [15:0] r_confirm;

    // Qualifier state and its next values.
    logic [POS_BITS-1:0]  r_cur_x, r_cur_y, n_cur_x, n_cur_y;
    logic signed [1:0]    r_carry_x, r_carry_y, n_carry_x, n_carry_y;
    logic [1:0]           r_raw, r_acc, r_pp, r_mb, n_raw, n_acc, n_pp, n_mb;
    logic                 r_mp, n_mp;
    logic [TIME_BITS-1:0] r_lpt, r_rpt, r_tick, n_lpt, n_rpt, n_tick;

    logic                 accept;
    t_scaled              scl_x, scl_y;
    logic signed [CW-1:0] sum_x, sum_y, set_x, set_y;
    logic [1:0]           btns, chg;
    logic [TIME_BITS-1:0] tick_inc, diff_l, diff_r, conf_t;
    t_bundle              evs;
    logic [POS_BITS+11:0] pad_x, pad_y;
    logic [TIME_BITS+31:0] pad_t;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_q_ready;
    assign accept      = i_in.valid && i_q_ready;

    // Operand preparation for the commands.
    assign btns     = i_in.button_byte[1:0];
    assign chg      = btns ^ r_raw;
    assign scl_x    = scale_delta(i_in.move_x, r_carry_x, r_mode);
    assign scl_y    = scale_delta(i_in.move_y, r_carry_y, r_mode);
    assign sum_x    = $signed({{(CW-POS_BITS){1'b0}}, r_cur_x})
                    + $signed({{(CW-10){scl_x.delta[9]}}, scl_x.delta});
    assign sum_y    = $signed({{(CW-POS_BITS){1'b0}}, r_cur_y})
                    + $signed({{(CW-10){scl_y.delta[9]}}, scl_y.delta});
    assign set_x    = $signed({{(CW-12){1'b0}}, i_in.new_x});
    assign set_y    = $signed({{(CW-12){1'b0}}, i_in.new_y});
    assign tick_inc = r_tick + TIME_BITS'(1);
    assign diff_l   = tick_inc - r_lpt;
    assign diff_r   = tick_inc - r_rpt;
    assign conf_t   = TIME_BITS'(r_confirm);

    // Command decode: next state and the list of events, in issue order.
    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_carry_x = r_carry_x;
        n_carry_y = r_carry_y;
        n_raw     = r_raw;
        n_acc     = r_acc;
        n_pp      = r_pp;
        n_mb      = r_mb;
        n_mp      = r_mp;
        n_lpt     = r_lpt;
        n_rpt     = r_rpt;
        n_tick    = r_tick;
        evs       = '0;
        case (i_in.command)
            CMD_REPORT: begin
                n_carry_x = scl_x.carry;
                n_carry_y = scl_y.carry;
                if (scl_x.delta != 10'sd0 || scl_y.delta != 10'sd0) begin
                    n_cur_x = clamp_axis(sum_x, r_width);
                    n_cur_y = clamp_axis(sum_y, r_height);
                    n_mp    = 1'b1;
                    n_mb    = btns;
                end
                if (chg[BIT_LEFT]) begin
                    if (btns[BIT_LEFT]) begin
                        n_pp[BIT_LEFT] = 1'b1;
                        n_lpt          = r_tick;
                    end else begin
                        n_pp[BIT_LEFT] = 1'b0;
                        if (r_acc[BIT_LEFT]) begin
                            if (n_mp) begin
                                evs  = push_event(evs, EV_MOVE, n_mb);
                                n_mp = 1'b0;
                            end
                            evs             = push_event(evs, EV_UP, btns);
                            n_acc[BIT_LEFT] = 1'b0;
                        end
                    end
                end
                if (chg[BIT_RIGHT]) begin
                    if (btns[BIT_RIGHT]) begin
                        n_pp[BIT_RIGHT] = 1'b1;
                        n_rpt           = r_tick;
                    end else begin
                        n_pp[BIT_RIGHT]  = 1'b0;
                        n_acc[BIT_RIGHT] = 1'b0;
                    end
                end
                n_raw = btns;
                // A press seen again in a later report is confirmed.
                if (n_pp[BIT_LEFT] && btns[BIT_LEFT] && !chg[BIT_LEFT]) begin
                    if (n_mp) begin
                        evs  = push_event(evs, EV_MOVE, n_mb);
                        n_mp = 1'b0;
                    end
                    evs             = push_event(evs, EV_DOWN, btns);
                    n_pp[BIT_LEFT]  = 1'b0;
                    n_acc[BIT_LEFT] = 1'b1;
                end
                if (n_pp[BIT_RIGHT] && btns[BIT_RIGHT] && !chg[BIT_RIGHT]) begin
                    if (n_mp) begin
                        evs  = push_event(evs, EV_MOVE, n_mb);
                        n_mp = 1'b0;
                    end
                    evs              = push_event(evs, EV_BACK, btns);
                    n_pp[BIT_RIGHT]  = 1'b0;
                    n_acc[BIT_RIGHT] = 1'b1;
                end
                if (i_in.wheel_step != 8'sd0) begin
                    if (n_mp) begin
                        evs  = push_event(evs, EV_MOVE, n_mb);
                        n_mp = 1'b0;
                    end
                    evs        = push_event(evs, EV_SCROLL, btns);
                    evs.scroll = i_in.wheel_step;
                end
            end
            CMD_TICK: begin
                n_tick = tick_inc;
                // A press held long enough is confirmed without a new report.
                if (r_pp[BIT_LEFT] && r_raw[BIT_LEFT] && diff_l >= conf_t) begin
                    if (n_mp) begin
                        evs  = push_event(evs, EV_MOVE, n_mb);
                        n_mp = 1'b0;
                    end
                    evs             = push_event(evs, EV_DOWN, r_raw);
                    n_pp[BIT_LEFT]  = 1'b0;
                    n_acc[BIT_LEFT] = 1'b1;
                end
                if (r_pp[BIT_RIGHT] && r_raw[BIT_RIGHT] && diff_r >= conf_t) begin
                    if (n_mp) begin
                        evs  = push_event(evs, EV_MOVE, n_mb);
                        n_mp = 1'b0;
                    end
                    evs              = push_event(evs, EV_BACK, r_raw);
                    n_pp[BIT_RIGHT]  = 1'b0;
                    n_acc[BIT_RIGHT] = 1'b1;
                end
            end
            CMD_FLUSH: begin
                if (r_mp) begin
                    evs  = push_event(evs, EV_MOVE, r_mb);
                    n_mp = 1'b0;
                end
            end
            CMD_REBASELINE, CMD_DISCONNECT: begin
                // The pending move is dropped, not flushed.
                n_carry_x = 2'sb00;
                n_carry_y = 2'sb00;
                n_pp      = 2'b00;
                n_mp      = 1'b0;
                n_mb      = 2'b00;
                n_lpt     = '0;
                n_rpt     = '0;
                if (r_acc[BIT_LEFT]) begin
                    evs = push_event(evs, EV_UP, 2'b00);
                end
                n_acc = 2'b00;
                n_raw = (i_in.command == CMD_REBASELINE) ? btns : 2'b00;
            end
            CMD_SET_POS: begin
                n_cur_x = clamp_axis(set_x, r_width);
                n_cur_y = clamp_axis(set_y, r_height);
            end
            default: begin
            end
        endcase
    end

    // Cursor and time as the events carry them.
    assign pad_x = {12'b0, n_cur_x};
    assign pad_y = {12'b0, n_cur_y};
    assign pad_t = {32'b0, n_tick};

    always_comb begin
        o_q_data            = evs;
        o_q_data.pointer_x  = pad_x[11:0];
        o_q_data.pointer_y  = pad_y[11:0];
        o_q_data.time_stamp = pad_t[31:0];
    end

    // Items that cause no event never enter the queue.
    assign o_q_push = accept && (evs.count != 3'd0);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= RST_MODE;
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
            r_confirm <= RST_CONFIRM;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODE:    r_mode    <= i_cfg.data[1:0];
                REG_WIDTH:   r_width   <= i_cfg.data[12:0];
                REG_HEIGHT:  r_height  <= i_cfg.data[12:0];
                REG_CONFIRM: r_confirm <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Qualifier state advances once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x   <= RST_X;
            r_cur_y   <= RST_Y;
            r_carry_x <= 2'sb00;
            r_carry_y <= 2'sb00;
            r_raw     <= 2'b00;
            r_acc     <= 2'b00;
            r_pp      <= 2'b00;
            r_mb      <= 2'b00;
            r_mp      <= 1'b0;
            r_lpt     <= '0;
            r_rpt     <= '0;
            r_tick    <= '0;
        end else if (accept) begin
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_carry_x <= n_carry_x;
            r_carry_y <= n_carry_y;
            r_raw     <= n_raw;
            r_acc     <= n_acc;
            r_pp      <= n_pp;
            r_mb      <= n_mb;
            r_mp      <= n_mp;
            r_lpt     <= n_lpt;
            r_rpt     <= n_rpt;
            r_tick    <= n_tick;
        end
    end

endmodule

// ----- rtl/core/prq_queue.sv -----
module prq_queue
    import prq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_data,
    output logic    o_ready,
    input  logic    i_pop,
    output logic    o_valid,
    output t_bundle o_data
);

    localparam int PW = (PRQ_QDEPTH > 1) ? $clog2(PRQ_QDEPTH) : 1;
    localparam int CNTW = $clog2(PRQ_QDEPTH + 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(PRQ_QDEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(PRQ_QDEPTH - 1);

    t_bundle         r_mem [PRQ_QDEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0] r_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage for queued bundles.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

endmodule

// ----- rtl/core/prq_back.sv -----
module prq_back
    import prq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_bundle   i_q_data,
    output logic      o_q_pop,
    prq_out_if.source o_out
);

    logic [1:0]        r_idx;
    logic              r_valid;
    logic [2:0]        r_kind;
    logic [11:0]       r_px, r_py;
    logic signed [7:0] r_scroll;
    logic [1:0]        r_btn;
    logic [31:0]       r_time;
    logic              r_last;

    logic       load;
    logic       is_last;
    logic [2:0] sel_kind;

    // The output register takes the next event whenever it is free or being drained.
    assign load     = i_q_valid && (!r_valid || o_out.ready);
    assign is_last  = ({1'b0, r_idx} == (i_q_data.count - 3'd1));
    assign sel_kind = i_q_data.kind[r_idx];
    assign o_q_pop  = load && is_last;

    // Walk through the events of the head bundle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Event payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= sel_kind;
            r_px     <= i_q_data.pointer_x;
            r_py     <= i_q_data.pointer_y;
            r_scroll <= (sel_kind == EV_SCROLL) ? i_q_data.scroll : 8'sd0;
            r_btn    <= i_q_data.btn[r_idx];
            r_time   <= i_q_data.time_stamp;
            r_last   <= is_last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.event_kind  = r_kind;
    assign o_out.pointer_x   = r_px;
    assign o_out.pointer_y   = r_py;
    assign o_out.scroll      = r_scroll;
    assign o_out.button_bits = r_btn;
    assign o_out.time_stamp  = r_time;
    assign o_out.last_of_run = r_last;

endmodule
